>>> hw/rtl/yrg_pkg.sv
// Shared types, constants and the helper function of the YUYV to RGB converter with gains.
package yrg_pkg;

   localparam int PixW      = 8;
   localparam int GainW     = 10;
   localparam int GainShift = 8;
   localparam int FracW     = 14;
   localparam int ChanW     = 9;
   localparam int SumW      = 24;
   localparam int CoefW     = 16;
   localparam int ProdW     = ChanW + GainW;
   localparam int ScaledW   = ProdW - GainShift;
   localparam int AddrW     = 4;
   localparam int DataW     = 32;

   localparam logic [PixW-1:0] PixMax = 8'd255;

   // Color matrix coefficients, scaled by 2^14 and rounded.
   localparam logic signed [CoefW-1:0] CoefRv = 16'sd23060;
   localparam logic signed [CoefW-1:0] CoefGu = 16'sd5661;
   localparam logic signed [CoefW-1:0] CoefGv = 16'sd11746;
   localparam logic signed [CoefW-1:0] CoefBu = 16'sd29147;

   localparam logic [GainW-1:0] LumaGainReset  = 10'd307;
   localparam logic [GainW-1:0] RedGainReset   = 10'd320;
   localparam logic [GainW-1:0] GreenGainReset = 10'd218;
   localparam logic [GainW-1:0] BlueGainReset  = 10'd218;

   typedef enum logic [1:0] {
      RegLumaGain  = 2'd0,
      RegRedGain   = 2'd1,
      RegGreenGain = 2'd2,
      RegBlueGain  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [PixW-1:0] luma_first;
      logic [PixW-1:0] chroma_blue;
      logic [PixW-1:0] luma_second;
      logic [PixW-1:0] chroma_red;
   } pixel_in_type;

   typedef struct packed {
      logic [PixW-1:0] red_first;
      logic [PixW-1:0] green_first;
      logic [PixW-1:0] blue_first;
      logic [PixW-1:0] red_second;
      logic [PixW-1:0] green_second;
      logic [PixW-1:0] blue_second;
   } pixel_out_type;

   typedef struct packed {
      logic [GainW-1:0] luma_gain;
      logic [GainW-1:0] red_gain;
      logic [GainW-1:0] green_gain;
      logic [GainW-1:0] blue_gain;
   } gains_type;

   // Scaled lumas as integers and the four chroma products in Q14.
   typedef struct packed {
      logic [PixW-1:0]        luma_first;
      logic [PixW-1:0]        luma_second;
      logic signed [SumW-1:0] term_rv;
      logic signed [SumW-1:0] term_gu;
      logic signed [SumW-1:0] term_gv;
      logic signed [SumW-1:0] term_bu;
   } front_type;

   // Integer channel values before the channel gains, negatives already forced to zero.
   typedef struct packed {
      logic [ChanW-1:0] red_first;
      logic [ChanW-1:0] green_first;
      logic [ChanW-1:0] blue_first;
      logic [ChanW-1:0] red_second;
      logic [ChanW-1:0] green_second;
      logic [ChanW-1:0] blue_second;
   } channel_type;

   // Multiply by an unsigned Q8 gain, drop the fraction and saturate to 255.
   function automatic logic [PixW-1:0] scale_sat(input logic [ChanW-1:0] value,
                                                 input logic [GainW-1:0] gain);
      logic [ProdW-1:0]   prod;
      logic [ScaledW-1:0] scaled;
      prod   = ProdW'(value) * ProdW'(gain);
      scaled = prod[ProdW-1:GainShift];
      if (scaled > ScaledW'(PixMax)) begin
         return PixMax;
      end else begin
         return scaled[PixW-1:0];
      end
   endfunction

endpackage

>>> hw/rtl/yrg_csr.sv
// Gain registers behind the APB-style configuration port.
module yrg_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [yrg_pkg::AddrW-1:0] paddr,
   input  logic [yrg_pkg::DataW-1:0] pwdata,
   output logic [yrg_pkg::DataW-1:0] prdata,
   output logic                      pready,
   output yrg_pkg::gains_type        gains
);

   yrg_pkg::gains_type     gains_ff;
   yrg_pkg::gains_type     gains_in;
   yrg_pkg::reg_index_type index;
   logic                   wr_en;

   assign index  = yrg_pkg::reg_index_type'(paddr[yrg_pkg::AddrW-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign gains  = gains_ff;

   always_comb begin
      gains_in = gains_ff;
      prdata   = '0;
      case (index)
         yrg_pkg::RegLumaGain: begin
            prdata = yrg_pkg::DataW'(gains_ff.luma_gain);
            if (wr_en) gains_in.luma_gain = pwdata[yrg_pkg::GainW-1:0];
         end
         yrg_pkg::RegRedGain: begin
            prdata = yrg_pkg::DataW'(gains_ff.red_gain);
            if (wr_en) gains_in.red_gain = pwdata[yrg_pkg::GainW-1:0];
         end
         yrg_pkg::RegGreenGain: begin
            prdata = yrg_pkg::DataW'(gains_ff.green_gain);
            if (wr_en) gains_in.green_gain = pwdata[yrg_pkg::GainW-1:0];
         end
         yrg_pkg::RegBlueGain: begin
            prdata = yrg_pkg::DataW'(gains_ff.blue_gain);
            if (wr_en) gains_in.blue_gain = pwdata[yrg_pkg::GainW-1:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.luma_gain  <= yrg_pkg::LumaGainReset;
         gains_ff.red_gain   <= yrg_pkg::RedGainReset;
         gains_ff.green_gain <= yrg_pkg::GreenGainReset;
         gains_ff.blue_gain  <= yrg_pkg::BlueGainReset;
      end else begin
         gains_ff <= gains_in;
      end
   end

endmodule

>>> hw/rtl/yrg_front.sv
// First stage: luma brightness gain and the four chroma coefficient products.
module yrg_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  yrg_pkg::pixel_in_type in_data,
   input  yrg_pkg::gains_type    gains,
   output logic                  out_valid,
   output yrg_pkg::front_type    out_data
);

   logic                            valid_ff;
   yrg_pkg::front_type              data_ff;
   yrg_pkg::front_type              data_in;
   logic signed [yrg_pkg::PixW-1:0] du;
   logic signed [yrg_pkg::PixW-1:0] dv;

   // Removing the 128 offset is just an inversion of the top bit.
   assign du = {~in_data.chroma_blue[yrg_pkg::PixW-1], in_data.chroma_blue[yrg_pkg::PixW-2:0]};
   assign dv = {~in_data.chroma_red[yrg_pkg::PixW-1], in_data.chroma_red[yrg_pkg::PixW-2:0]};

   always_comb begin
      data_in.luma_first  = yrg_pkg::scale_sat({1'b0, in_data.luma_first}, gains.luma_gain);
      data_in.luma_second = yrg_pkg::scale_sat({1'b0, in_data.luma_second}, gains.luma_gain);
      data_in.term_rv     = yrg_pkg::SumW'(dv) * yrg_pkg::SumW'(yrg_pkg::CoefRv);
      data_in.term_gu     = yrg_pkg::SumW'(du) * yrg_pkg::SumW'(yrg_pkg::CoefGu);
      data_in.term_gv     = yrg_pkg::SumW'(dv) * yrg_pkg::SumW'(yrg_pkg::CoefGv);
      data_in.term_bu     = yrg_pkg::SumW'(du) * yrg_pkg::SumW'(yrg_pkg::CoefBu);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> hw/rtl/yrg_matrix.sv
// Second stage: Q14 color matrix sums, truncated to integer channel values.
module yrg_matrix (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  yrg_pkg::front_type   in_data,
   output logic                 out_valid,
   output yrg_pkg::channel_type out_data
);

   logic                            valid_ff;
   yrg_pkg::channel_type            data_ff;
   yrg_pkg::channel_type            data_in;
   logic signed [yrg_pkg::SumW-1:0] yq_first;
   logic signed [yrg_pkg::SumW-1:0] yq_second;
   logic signed [yrg_pkg::SumW-1:0] sum_r_first;
   logic signed [yrg_pkg::SumW-1:0] sum_g_first;
   logic signed [yrg_pkg::SumW-1:0] sum_b_first;
   logic signed [yrg_pkg::SumW-1:0] sum_r_second;
   logic signed [yrg_pkg::SumW-1:0] sum_g_second;
   logic signed [yrg_pkg::SumW-1:0] sum_b_second;

   // A negative sum is forced to zero; a non-negative sum is truncated to its integer part.
   function automatic logic [yrg_pkg::ChanW-1:0] to_chan(input logic signed [yrg_pkg::SumW-1:0] s);
      if (s[yrg_pkg::SumW-1]) begin
         return '0;
      end else begin
         return s[yrg_pkg::FracW+yrg_pkg::ChanW-1:yrg_pkg::FracW];
      end
   endfunction

   assign yq_first  = yrg_pkg::SumW'({in_data.luma_first, yrg_pkg::FracW'(0)});
   assign yq_second = yrg_pkg::SumW'({in_data.luma_second, yrg_pkg::FracW'(0)});

   assign sum_r_first  = yq_first + in_data.term_rv;
   assign sum_g_first  = yq_first - in_data.term_gu - in_data.term_gv;
   assign sum_b_first  = yq_first + in_data.term_bu;
   assign sum_r_second = yq_second + in_data.term_rv;
   assign sum_g_second = yq_second - in_data.term_gu - in_data.term_gv;
   assign sum_b_second = yq_second + in_data.term_bu;

   always_comb begin
      data_in.red_first    = to_chan(sum_r_first);
      data_in.green_first  = to_chan(sum_g_first);
      data_in.blue_first   = to_chan(sum_b_first);
      data_in.red_second   = to_chan(sum_r_second);
      data_in.green_second = to_chan(sum_g_second);
      data_in.blue_second  = to_chan(sum_b_second);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> hw/rtl/yrg_gain.sv
// Third stage: per-channel gains with saturation, feeding the result register.
module yrg_gain (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  yrg_pkg::channel_type   in_data,
   input  yrg_pkg::gains_type     gains,
   output logic                   out_valid,
   output yrg_pkg::pixel_out_type out_data
);

   logic                   valid_ff;
   yrg_pkg::pixel_out_type data_ff;
   yrg_pkg::pixel_out_type data_in;

   always_comb begin
      data_in.red_first    = yrg_pkg::scale_sat(in_data.red_first, gains.red_gain);
      data_in.green_first  = yrg_pkg::scale_sat(in_data.green_first, gains.green_gain);
      data_in.blue_first   = yrg_pkg::scale_sat(in_data.blue_first, gains.blue_gain);
      data_in.red_second   = yrg_pkg::scale_sat(in_data.red_second, gains.red_gain);
      data_in.green_second = yrg_pkg::scale_sat(in_data.green_second, gains.green_gain);
      data_in.blue_second  = yrg_pkg::scale_sat(in_data.blue_second, gains.blue_gain);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> hw/rtl/yuyv_to_rgb_with_gains_core.sv
// Top level of the YUYV macropixel to RGB888 converter with brightness and channel gains.
//
// Each item is one YUYV macropixel (two lumas sharing one U and one V sample) and gives
// exactly one result of two RGB888 pixels. The block takes an item in every clock cycle:
// busy is always low, so an item is taken at every edge where start is high. The result
// appears on rsp_data with rsp_valid high for one cycle, and results leave in the order the
// items came in. Each item passes three register stages in turn: luma gain and chroma
// products, the Q14 color matrix sums, and the per-channel gains with saturation. The
// receiver cannot stall the block, so nothing is buffered beyond these stages. Gains are
// unsigned Q8 values in four registers at byte addresses 0 (luma), 4 (red), 8 (green) and
// 12 (blue); they are applied to items as they pass, so change them only while no item is
// in flight.
module yuyv_to_rgb_with_gains_core (
   input  logic                      clock,
   input  logic                      reset,
   // Item input
   input  logic                      start,
   output logic                      busy,
   input  yrg_pkg::pixel_in_type     req_data,
   // Result output
   output logic                      rsp_valid,
   output yrg_pkg::pixel_out_type    rsp_data,
   // Configuration port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [yrg_pkg::AddrW-1:0] paddr,
   input  logic [yrg_pkg::DataW-1:0] pwdata,
   output logic [yrg_pkg::DataW-1:0] prdata,
   output logic                      pready
);

   yrg_pkg::gains_type   gains;
   logic                 accept;
   logic                 front_valid;
   yrg_pkg::front_type   front_data;
   logic                 matrix_valid;
   yrg_pkg::channel_type matrix_data;

   // The pipeline never holds off an item.
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   yrg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .gains   (gains)
   );

   // Stage one: luma gain and the chroma coefficient products.
   yrg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_data),
      .gains     (gains),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   // Stage two: matrix sums and truncation to integer channels.
   yrg_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (matrix_valid),
      .out_data  (matrix_data)
   );

   // Stage three: channel gains and saturation into the result register.
   yrg_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (matrix_valid),
      .in_data   (matrix_data),
      .gains     (gains),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   // Every result comes from an accepted item that has passed the front, matrix and gain stages.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 3))
      else $error("result without a matching item three cycles earlier");

   // A red gain of zero forces both red outputs to zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && gains.red_gain == '0) |->
         (rsp_data.red_first == '0 && rsp_data.red_second == '0))
      else $error("red output not zero under zero red gain");

   // Equal lumas in one item give two identical pixels.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_data.luma_first == req_data.luma_second, 3)) |->
         (rsp_data.red_first == rsp_data.red_second &&
          rsp_data.green_first == rsp_data.green_second &&
          rsp_data.blue_first == rsp_data.blue_second))
      else $error("pixels of equal luma differ");

endmodule
